@@ hdl/flc_pkg.sv @@
// Shared types and constants for the false-color LUT interpolator.
// No dependencies; used by flc_blend and false_color_lut_interpolator.
`timescale 1ns / 1ps
`default_nettype none

package flc_pkg;

   localparam int STOP_REGS     = 6;
   localparam int DEF_NUM_STOPS = 6;
   localparam int CHAN_W        = 8;
   localparam int COLOR_W       = 3 * CHAN_W;
   localparam int LEVEL_W       = 16;
   localparam int GAIN_W        = 16;
   localparam int DIFF_W        = LEVEL_W + 1;
   localparam int POS_W         = DIFF_W + GAIN_W + 1;
   localparam int STOP_IDX_W    = $clog2(STOP_REGS);
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = COLOR_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_0    = 3'd2;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN_RESET  = -16'sd512;
   localparam logic [GAIN_W-1:0]         LEVEL_GAIN_RESET = 16'd256;
   // stop 5 in the top bits, stop 0 in the bottom bits
   localparam logic [STOP_REGS*COLOR_W-1:0] COLOR_RESET = {
      24'hFFFFFF, 24'hFFFF00, 24'hFF0000, 24'h000000, 24'h0000FF, 24'h000080
   };

   typedef struct packed {
      logic [COLOR_W-1:0] color_a;
      logic [COLOR_W-1:0] color_b;
      logic [CHAN_W-1:0]  frac;
   } blend_req_type;

   // stop color by index; an index past the last register reads as zero
   function automatic logic [COLOR_W-1:0] pick_color(
      input logic [STOP_REGS*COLOR_W-1:0] colors,
      input logic [STOP_IDX_W-1:0]        idx
   );
      logic [COLOR_W-1:0] result;
      result = '0;
      for (int i = 0; i < STOP_REGS; i++) begin
         if (idx == STOP_IDX_W'(i)) begin
            result = colors[i*COLOR_W +: COLOR_W];
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ hdl/flc_blend.sv @@
// Blend stage: mixes two stop colors per 8-bit channel with rounding.
// Depends on flc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flc_blend (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire flc_pkg::blend_req_type     in_req,
   output logic                            out_valid,
   output logic [flc_pkg::COLOR_W-1:0]     out_color
);

   localparam int PROD_W = 2 * flc_pkg::CHAN_W + 1;

   logic                           valid_ff;
   logic [flc_pkg::COLOR_W-1:0]    color_ff;
   logic [flc_pkg::COLOR_W-1:0]    color_in;
   logic [flc_pkg::CHAN_W:0]       inv_frac;

   assign inv_frac = (flc_pkg::CHAN_W + 1)'(1 << flc_pkg::CHAN_W)
                   - {1'b0, in_req.frac};

   always_comb begin
      logic [PROD_W-1:0] mix;
      color_in = '0;
      for (int k = 0; k < 3; k++) begin
         mix = PROD_W'(in_req.color_a[k*flc_pkg::CHAN_W +: flc_pkg::CHAN_W] * inv_frac)
             + PROD_W'(in_req.color_b[k*flc_pkg::CHAN_W +: flc_pkg::CHAN_W] * in_req.frac)
             + PROD_W'(1 << (flc_pkg::CHAN_W - 1));
         color_in[k*flc_pkg::CHAN_W +: flc_pkg::CHAN_W] =
            mix[flc_pkg::CHAN_W +: flc_pkg::CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      color_ff <= color_in;
   end

   assign out_valid = valid_ff;
   assign out_color = color_ff;

endmodule

`default_nettype wire

@@ hdl/false_color_lut_interpolator.sv @@
// Top level of the false-color LUT interpolator: register file, level
// scaling and stop selection. Depends on flc_pkg and flc_blend.
`timescale 1ns / 1ps
`default_nettype none

// Maps a signed Q8.8 level to an RGB pixel by linear interpolation
// between color stops.
// Input: a word is taken at each rising edge where start is high and
// busy is low. busy is always low: the pipeline takes one word every
// cycle with no gaps.
// Output: rsp_valid marks one cycle with rsp_red/green/blue. The result
// of a taken word passes four register stages (subtract, multiply, stop
// select, blend) before it is on the ports.
// Throughput: one pixel per clock, set by the fully pipelined datapath.
// The receiver cannot stall; results are never held back.
// Config: csr_we writes csr_wdata into register csr_index (level_min,
// level_gain, color_0..color_5). Write only while no word is in flight.
// Reset (synchronous) empties the pipeline and loads the default
// registers; no clearing pass is needed.
module false_color_lut_interpolator #(
   parameter int NUM_STOPS = flc_pkg::DEF_NUM_STOPS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [flc_pkg::LEVEL_W-1:0] req_level,
   output logic                                    rsp_valid,
   output logic [flc_pkg::CHAN_W-1:0]              rsp_red,
   output logic [flc_pkg::CHAN_W-1:0]              rsp_green,
   output logic [flc_pkg::CHAN_W-1:0]              rsp_blue,
   input  wire logic                               csr_we,
   input  wire logic [flc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [flc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = flc_pkg::POS_W - 18;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STOPS - 1);
   localparam logic [flc_pkg::STOP_IDX_W-1:0] LAST_STOP =
      flc_pkg::STOP_IDX_W'(NUM_STOPS - 1);

   // config registers
   logic signed [flc_pkg::LEVEL_W-1:0]               level_min_ff;
   logic [flc_pkg::GAIN_W-1:0]                       level_gain_ff;
   logic [flc_pkg::STOP_REGS*flc_pkg::COLOR_W-1:0]   colors_ff;
   logic [flc_pkg::CSR_IDX_W-1:0]                    color_wr_idx;

   // pipeline
   logic                                 accept;
   logic                                 s1_valid_ff;
   logic signed [flc_pkg::DIFF_W-1:0]    diff_ff;
   logic                                 s2_valid_ff;
   logic signed [flc_pkg::POS_W-1:0]     pos_ff;
   logic signed [flc_pkg::POS_W-1:0]     pos_in;
   logic                                 s3_valid_ff;
   flc_pkg::blend_req_type               blend_req_ff;
   flc_pkg::blend_req_type               blend_req_in;
   logic [IDX_W-1:0]                     pos_idx;
   logic [flc_pkg::STOP_IDX_W-1:0]       sel_a;
   logic [flc_pkg::COLOR_W-1:0]          out_color;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign color_wr_idx = csr_index - flc_pkg::CSR_COLOR_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_min_ff  <= flc_pkg::LEVEL_MIN_RESET;
         level_gain_ff <= flc_pkg::LEVEL_GAIN_RESET;
         colors_ff     <= flc_pkg::COLOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            flc_pkg::CSR_LEVEL_MIN:  level_min_ff  <= csr_wdata[flc_pkg::LEVEL_W-1:0];
            flc_pkg::CSR_LEVEL_GAIN: level_gain_ff <= csr_wdata[flc_pkg::GAIN_W-1:0];
            default: begin
               for (int i = 0; i < flc_pkg::STOP_REGS; i++) begin
                  if (color_wr_idx == flc_pkg::CSR_IDX_W'(i)) begin
                     colors_ff[i*flc_pkg::COLOR_W +: flc_pkg::COLOR_W] <= csr_wdata;
                  end
               end
            end
         endcase
      end
   end

   // stage 2: position, 16 fraction bits
   assign pos_in = diff_ff * $signed({1'b0, level_gain_ff});

   // stage 3: clamp and pick the two stops; clamped words blend with f = 0
   assign pos_idx = pos_ff[flc_pkg::POS_W-3:16];

   always_comb begin
      priority if (pos_ff[flc_pkg::POS_W-1]) begin
         sel_a = '0;
         blend_req_in.frac = '0;
      end else if (pos_idx >= LAST_IDX) begin
         sel_a = LAST_STOP;
         blend_req_in.frac = '0;
      end else begin
         sel_a = pos_idx[flc_pkg::STOP_IDX_W-1:0];
         blend_req_in.frac = pos_ff[15:8];
      end
      blend_req_in.color_a = flc_pkg::pick_color(colors_ff, sel_a);
      blend_req_in.color_b = flc_pkg::pick_color(colors_ff, sel_a + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      diff_ff      <= flc_pkg::DIFF_W'(req_level) - flc_pkg::DIFF_W'(level_min_ff);
      pos_ff       <= pos_in;
      blend_req_ff <= blend_req_in;
   end

   // stage 4: per-channel blend
   flc_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_req    (blend_req_ff),
      .out_valid (rsp_valid),
      .out_color (out_color)
   );

   assign rsp_red   = out_color[2*flc_pkg::CHAN_W +: flc_pkg::CHAN_W];
   assign rsp_green = out_color[flc_pkg::CHAN_W +: flc_pkg::CHAN_W];
   assign rsp_blue  = out_color[0 +: flc_pkg::CHAN_W];

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted word produced no result after four cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("result without a matching accepted word");

   a_clamp_frac: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && pos_ff[flc_pkg::POS_W-1] |=> blend_req_ff.frac == '0)
      else $error("negative position not clamped to first stop");

   a_flat_blend: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && blend_req_ff.frac == '0 |=> out_color == $past(blend_req_ff.color_a))
      else $error("zero fraction must pass stop color unchanged");
`endif

endmodule

`default_nettype wire
